// ===== hw/rtl/symmetric_fir_filter_defines.svh =====
// Assertion macros for the symmetric FIR filter.
// Used by symmetric_fir_filter.sv; no other dependencies.
`ifndef SYMMETRIC_FIR_FILTER_DEFINES_SVH
`define SYMMETRIC_FIR_FILTER_DEFINES_SVH
`ifndef SYNTH
// check a property while out of reset
`define SFF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("symmetric_fir_filter: assertion failed");
// check a property that involves reset itself
`define SFF_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("symmetric_fir_filter: reset assertion failed");
`else
`define SFF_ASSERT(label, prop)
`define SFF_ASSERT_RST(label, prop)
`endif
`endif

// ===== hw/rtl/sff_pkg.sv =====
// Package for the symmetric FIR filter: coefficient table and shared types.
// No dependencies.
package sff_pkg;

   typedef logic signed [15:0] coef_q15_type;

   localparam int HALF_TABLE = 24;

   // first half of the linear-phase low-pass response, Q1.15
   localparam coef_q15_type COEF_Q15 [HALF_TABLE] = '{
      -16'sd760, 16'sd53,   16'sd70,   16'sd100,  16'sd140,  16'sd192,
      16'sd253,  16'sd324,  16'sd402,  16'sd488,  16'sd579,  16'sd675,
      16'sd772,  16'sd871,  16'sd968,  16'sd1063, 16'sd1152, 16'sd1234,
      16'sd1310, 16'sd1374, 16'sd1428, 16'sd1469, 16'sd1497, 16'sd1511
   };

endpackage

// ===== hw/rtl/symmetric_fir_filter.sv =====
// Symmetric FIR low-pass filter, one sample in and one filtered sample out per item.
// Uses sff_pkg (coefficient table) and symmetric_fir_filter_defines.svh (assertions).
//
// Each item is one signed Q1.15 sample; the result is y[n] = sum b[k] x[n-k] over TAPS
// fixed linear-phase taps, rounded half up and saturated. Samples sharing a coefficient
// are pre-added, then each pair sum is multiplied bit-serially, one coefficient bit per
// cycle, into a wide accumulator. The next item is taken only once the current result
// has moved into the output register. One item is in work at a time; a finished result
// waits in the output register while the next item is taken. The history is held in a
// RAM of TAPS-1 entries with a valid bit per entry, so it reads as zero right after
// reset with no clearing pass.
module symmetric_fir_filter #(
   parameter int TAPS        = 48,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample_out
);

   localparam int SB      = SAMPLE_BITS;
   localparam int CB      = COEF_BITS;
   localparam int DEPTH   = TAPS - 1;
   localparam int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NSTEPS  = TAPS / 2 + TAPS % 2;
   localparam int KW      = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
   localparam int BW      = $clog2(CB);
   localparam int PS      = SB + CB;
   localparam int ACC_RAW = SB + CB + 2 + $clog2(NSTEPS + 1);
   localparam int ACC     = (ACC_RAW > 64) ? 64 : ACC_RAW;
   localparam int CUP     = (CB >= 16) ? CB - 16 : 0;
   localparam int CDN     = (CB < 16) ? 16 - CB : 0;

   localparam logic signed [ACC-1:0] Y_HI = {{(ACC-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [ACC-1:0] Y_LO = ~Y_HI;
   localparam logic [ACC-1:0]        HALF = {{(ACC-1){1'b0}}, 1'b1} << (CB - 2);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_MAC   = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // coefficient for table slot j, rescaled to Q1.(CB-1)
   function automatic logic signed [CB-1:0] coef_at(input logic [4:0] j);
      logic signed [31:0] c;
      logic signed [31:0] r;
      c = 32'(sff_pkg::COEF_Q15[j]);
      if (CB >= 16) begin
         r = c <<< CUP;
      end else begin
         r = (c + ((32'sd1 <<< CDN) >>> 1)) >>> CDN;
      end
      return CB'(r);
   endfunction

   logic [2:0]              state_ff, state_in;
   logic signed [SB-1:0]    x0_ff, x0_in;
   logic [PW-1:0]           wp_ff, wp_in;
   logic [PW-1:0]           pa_ff, pa_in;
   logic [PW-1:0]           pb_ff, pb_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [BW-1:0]           bit_ff, bit_in;
   logic signed [PS-1:0]    pair_ff, pair_in;
   logic [CB-1:0]           coef_ff, coef_in;
   logic signed [ACC-1:0]   acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]      rsp_data_ff, rsp_data_in;
   logic [DEPTH-1:0]        vld_ff, vld_in;
   logic                    rdav_ff, rdav_in;
   logic                    rdbv_ff, rdbv_in;

   logic signed [SB-1:0]    mem [DEPTH];
   logic signed [SB-1:0]    rda_ff;
   logic signed [SB-1:0]    rdb_ff;

   logic                    out_free;
   logic                    commit;
   logic                    last_step;
   logic                    single_step;
   logic [4:0]              tab_idx;
   logic signed [SB-1:0]    a_val;
   logic signed [SB-1:0]    b_val;
   logic signed [SB:0]      pair_sum;
   logic signed [ACC-1:0]   term;
   logic signed [ACC-1:0]   rnd;
   logic signed [SB-1:0]    sat;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign commit      = (state_ff == ST_DONE) && out_free;
   assign last_step   = (k_ff == KW'(NSTEPS - 1));
   assign single_step = (TAPS % 2 == 1) && (k_ff == KW'(TAPS / 2));

   // table slot: pair k uses min(k, 23)
   always_comb begin
      if (32'(k_ff) >= sff_pkg::HALF_TABLE - 1) begin
         tab_idx = 5'(sff_pkg::HALF_TABLE - 1);
      end else begin
         tab_idx = 5'(k_ff);
      end
   end

   // pair operands: newest tap is the held input, history entries read as zero until written
   always_comb begin
      a_val    = (k_ff == KW'(0)) ? x0_ff : (rdav_ff ? rda_ff : '0);
      b_val    = (single_step || !rdbv_ff) ? '0 : rdb_ff;
      pair_sum = (SB+1)'(a_val) + (SB+1)'(b_val);
      term     = ACC'(pair_ff);
      rnd      = acc_ff + HALF;
   end

   // saturate the rounded sum to the sample range
   always_comb begin
      if (acc_ff > Y_HI) begin
         sat = {1'b0, {(SB-1){1'b1}}};
      end else if (acc_ff < Y_LO) begin
         sat = {1'b1, {(SB-1){1'b0}}};
      end else begin
         sat = acc_ff[SB-1:0];
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      x0_in        = x0_ff;
      wp_in        = wp_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      k_in         = k_ff;
      bit_in       = bit_ff;
      pair_in      = pair_ff;
      coef_in      = coef_ff;
      acc_in       = acc_ff;
      vld_in       = vld_ff;
      rdav_in      = vld_ff[pa_ff];
      rdbv_in      = vld_ff[pb_ff];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x0_in    = SB'(32'(unsigned'(req_sample_in)));
               pa_in    = (wp_ff == '0) ? PW'(DEPTH - 1) : wp_ff - PW'(1);
               pb_in    = wp_ff;
               k_in     = '0;
               acc_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            pair_in  = PS'(pair_sum);
            coef_in  = coef_at(tab_idx);
            bit_in   = '0;
            // newer-side pointer steps back after each pair but the first
            if (k_ff != KW'(0)) begin
               pa_in = (pa_ff == '0) ? PW'(DEPTH - 1) : pa_ff - PW'(1);
            end
            pb_in    = (pb_ff == PW'(DEPTH - 1)) ? '0 : pb_ff + PW'(1);
            state_in = ST_MAC;
         end
         ST_MAC: begin
            // one coefficient bit per cycle; the top bit carries negative weight
            if (coef_ff[0]) begin
               if (bit_ff == BW'(CB - 1)) begin
                  acc_in = acc_ff - term;
               end else begin
                  acc_in = acc_ff + term;
               end
            end
            pair_in = pair_ff <<< 1;
            coef_in = coef_ff >> 1;
            bit_in  = bit_ff + BW'(1);
            if (bit_ff == BW'(CB - 1)) begin
               if (last_step) begin
                  state_in = ST_ROUND;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_ROUND: begin
            acc_in   = rnd >>> (CB - 1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // publish the result and retire the sample into the history
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = 16'(sat);
               vld_in[wp_ff] = 1'b1;
               wp_in         = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      k_ff        <= k_in;
      bit_ff      <= bit_in;
      pair_ff     <= pair_in;
      coef_ff     <= coef_in;
      acc_ff      <= acc_in;
      rdav_ff     <= rdav_in;
      rdbv_ff     <= rdbv_in;
      rsp_data_ff <= rsp_data_in;
   end

   // history RAM: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (commit) begin
         mem[wp_ff] <= x0_ff;
      end
      rda_ff <= mem[pa_ff];
      rdb_ff <= mem[pb_ff];
   end

`include "symmetric_fir_filter_defines.svh"

   `SFF_ASSERT_RST(a_reset_idle, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff)
   `SFF_ASSERT(a_accept_starts, (req_valid && req_ready) |=> (state_ff == ST_READ) && (k_ff == '0))
   `SFF_ASSERT(a_result_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
   `SFF_ASSERT(a_mac_bit_range, (state_ff == ST_MAC) |-> (32'(bit_ff) < CB))

endmodule

// ===== verif/tb_symmetric_fir_filter.sv =====
// Self-checking testbench for the 48-tap symmetric FIR low-pass filter.
// Depends on sff_pkg (coefficient table) and the symmetric_fir_filter RTL.
`timescale 1ns / 1ps

module tb_symmetric_fir_filter;

   localparam int TAP_COUNT   = 48;
   localparam int HISTORY_LEN = TAP_COUNT - 1;
   localparam int FRAC_BITS   = 15;
   localparam int ITEM_TARGET = 800;
   localparam int DRAIN_WAIT  = 450;   // a little over one item's latency

   localparam logic signed [15:0] FULL_POS = 16'sh7fff;
   localparam logic signed [15:0] FULL_NEG = -16'sh8000;

   // stream shapes for the random part
   typedef enum int {
      SHAPE_WIDE,
      SHAPE_SMALL,
      SHAPE_CONSTANT,
      SHAPE_ALTERNATE,
      SHAPE_SPARSE,
      SHAPE_NEAR_RAIL
   } stream_shape_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_sample_in;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_sample_out;

   // predicted filter outputs, oldest first
   logic signed [15:0] expected_samples[$];

   // predictor state: past samples and slot of the oldest one
   logic signed [15:0] sample_history[HISTORY_LEN];
   int unsigned        oldest_slot;

   int  fail_count;
   int  items_sent;
   int  results_checked;
   bit  idle_enable;

   symmetric_fir_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next filter output for sample x; advances the history
   function automatic logic signed [15:0] filter_predict(input logic signed [15:0] x);
      longint      acc;
      longint      newer;
      longint      older;
      longint      y;
      int unsigned k;
      acc = 0;
      for (k = 0; k < TAP_COUNT / 2; k++) begin
         newer = (k == 0) ? longint'(x)
                          : longint'(sample_history[(oldest_slot + HISTORY_LEN - k) % HISTORY_LEN]);
         // partner of tap k is tap TAP_COUNT-1-k, counted from the oldest slot
         older = longint'(sample_history[(oldest_slot + k) % HISTORY_LEN]);
         acc += (newer + older) * longint'(sff_pkg::COEF_Q15[k]);
      end
      // round half up, then saturate to Q1.15
      acc += longint'(1) << (FRAC_BITS - 1);
      y = acc >>> FRAC_BITS;
      if (y < longint'(FULL_NEG))
         y = longint'(FULL_NEG);
      if (y > longint'(FULL_POS))
         y = longint'(FULL_POS);
      sample_history[oldest_slot] = x;
      oldest_slot = (oldest_slot + 1) % HISTORY_LEN;
      return y[15:0];
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idle_enable)
         return 0;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // drive one sample and record its expected output once accepted
   task automatic send_sample(input logic signed [15:0] x);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(filter_predict(x));
      items_sent++;
   endtask

   // hold the input side until every expected result is back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
   endtask

   // impulse right after reset: history must read as zero
   task automatic test_impulse_response();
      send_sample(FULL_POS);
      repeat (4) send_sample(16'sd0);
   endtask

   // both rails, neighbors of zero
   task automatic test_full_scale_extremes();
      send_sample(FULL_NEG);
      send_sample(FULL_NEG);
      send_sample(FULL_POS);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sd0);
   endtask

   // tiny inputs land on rounding boundaries
   task automatic test_small_value_rounding();
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd2);
      send_sample(-16'sd2);
      send_sample(16'sd16);
      send_sample(-16'sd16);
   endtask

   // long constant runs at the rails drive the output into saturation
   task automatic test_saturating_runs();
      int unsigned run;
      int unsigned len;
      for (run = 0; run < 4; run++) begin
         len = $urandom_range(50, 64);
         repeat (len) send_sample(run[0] ? FULL_NEG : FULL_POS);
      end
   endtask

   // back-to-back random samples with no idling on either side
   task automatic test_unthrottled_stream();
      idle_enable = 1'b0;
      repeat (40) send_sample(16'($urandom));
      wait_for_drain();
      idle_enable = 1'b1;
   endtask

   // random bursts of assorted shapes until the item target is reached
   task automatic test_random_stream();
      stream_shape_type   shape;
      logic signed [15:0] level;
      logic signed [15:0] x;
      int unsigned        len;
      int unsigned        i;
      while (items_sent < ITEM_TARGET) begin
         shape = stream_shape_type'($urandom_range(0, 5));
         len   = $urandom_range(8, 64);
         level = 16'($urandom);
         for (i = 0; i < len; i++) begin
            case (shape)
               SHAPE_WIDE:      x = 16'($urandom);
               SHAPE_SMALL:     x = 16'(int'($urandom_range(0, 16)) - 8);
               SHAPE_CONSTANT:  x = level;
               SHAPE_ALTERNATE: x = i[0] ? FULL_NEG : FULL_POS;
               SHAPE_SPARSE:    x = ($urandom_range(7) == 0) ? 16'($urandom) : 16'sd0;
               default:         x = $urandom_range(1)
                                    ? 16'(int'(FULL_POS) - int'($urandom_range(0, 3)))
                                    : 16'(int'(FULL_NEG) + int'($urandom_range(0, 3)));
            endcase
            send_sample(x);
         end
      end
   endtask

   // result side: random backpressure once out of reset
   initial begin
      int unsigned hold;
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         hold = $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (hold) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: no result expected, actual %0d", rsp_sample_out);
            fail_count++;
         end else begin
            want = expected_samples.pop_front();
            results_checked++;
            if (rsp_sample_out !== want) begin
               $error("sample_out: expected %0d, actual %0d", want, rsp_sample_out);
               fail_count++;
            end
         end
      end
   end

   // run guard
   initial begin
      #(64'd20_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_in   = 16'sd0;
      fail_count      = 0;
      items_sent      = 0;
      results_checked = 0;
      idle_enable     = 1'b1;
      oldest_slot     = 0;
      foreach (sample_history[i])
         sample_history[i] = 16'sd0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_impulse_response();
      test_full_scale_extremes();
      test_small_value_rounding();
      wait_for_drain();
      test_saturating_runs();
      test_unthrottled_stream();
      test_random_stream();

      // let the last results come back, then watch for strays
      wait_for_drain();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Filtered %0d samples: impulse, rail, rounding, saturating and random bursts",
               items_sent);
      $display("%0d outputs compared against the predicted response", results_checked);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
